FILE: rtl/rfae_pkg.sv
// Package: shared types, codes and constants of the register file ALU executor.
package rfae_pkg;

  localparam int unsigned IdxW = 6;
  localparam int unsigned DataW = 32;
  localparam int unsigned RegCountDef = 64;
  localparam int unsigned IdxSpan = 64;

  typedef enum logic [5:0] {
    CMD_NOP, CMD_MOVE, CMD_SELECT, CMD_ADD, CMD_SUB, CMD_MULU, CMD_MULS, CMD_MADDU,
    CMD_MADDS, CMD_DIVMODU, CMD_DIVMODS, CMD_AND, CMD_OR, CMD_XOR, CMD_NOT, CMD_SLL,
    CMD_SRL, CMD_SRA, CMD_ROR, CMD_CLZ, CMD_CLO, CMD_SLTU, CMD_SLTS, CMD_BSWAPH,
    CMD_BSWAPW, CMD_HSWAPW, CMD_ADDI, CMD_ANDI, CMD_ORI, CMD_XORI, CMD_SLLI, CMD_SRLI,
    CMD_SRAI, CMD_RORI, CMD_SLTUI, CMD_SLTSI, CMD_BFEXT, CMD_BFINS, CMD_LI
  } cmd_e;

  typedef enum logic [2:0] {
    CLS_NOP, CLS_ALU, CLS_MUL, CLS_MAC, CLS_DIV
  } cls_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_AB, ST_RD_CX, ST_EXEC, ST_MAC, ST_DIV, ST_WR_LO, ST_WR_HI, ST_OUT
  } state_e;

  typedef struct packed {
    logic [5:0]  cmd;
    logic [5:0]  dest_reg;
    logic [5:0]  dest2_reg;
    logic [5:0]  src1_reg;
    logic [5:0]  src2_reg;
    logic [5:0]  sel_reg;
    logic [31:0] imm;
    logic [4:0]  field_start;
    logic [4:0]  field_count;
  } in_item_t;

  typedef struct packed {
    logic [31:0] low_result;
    logic [31:0] high_result;
    logic        low_written;
    logic        high_written;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    cls_e     cls;
    logic     sgn;
  } q_item_t;

  typedef struct packed {
    logic [IdxW-1:0]  raddr0;
    logic [IdxW-1:0]  raddr1;
    logic             we;
    logic [IdxW-1:0]  waddr;
    logic [DataW-1:0] wdata;
  } rf_req_t;

endpackage

FILE: rtl/rfae_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module rfae_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rfae_pkg::in_item_t in_data_i,
  input  logic              pop_i,
  output logic              q_valid_o,
  output rfae_pkg::q_item_t q_data_o
);
  import rfae_pkg::*;

  q_item_t    entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push, pop;
  q_item_t    cls_item;

  always_comb begin
    cls_item.item = in_data_i;
    cls_item.sgn  = 1'b0;
    unique case (cmd_e'(in_data_i.cmd))
      CMD_NOP:                 cls_item.cls = CLS_NOP;
      CMD_MULU:                cls_item.cls = CLS_MUL;
      CMD_MULS: begin
        cls_item.cls = CLS_MUL;
        cls_item.sgn = 1'b1;
      end
      CMD_MADDU:               cls_item.cls = CLS_MAC;
      CMD_MADDS: begin
        cls_item.cls = CLS_MAC;
        cls_item.sgn = 1'b1;
      end
      CMD_DIVMODU:             cls_item.cls = CLS_DIV;
      CMD_DIVMODS: begin
        cls_item.cls = CLS_DIV;
        cls_item.sgn = 1'b1;
      end
      default: begin
        cls_item.cls = (in_data_i.cmd > 6'(CMD_LI)) ? CLS_NOP : CLS_ALU;
      end
    endcase
  end

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = pop_i && q_valid_o;
  assign q_data_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) entry_q[wr_ptr_q] <= cls_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/rfae_regs.sv
// Register file: two registered read ports, one write port, cleared by valid bits.
module rfae_regs #(
  parameter int unsigned RegCount = rfae_pkg::RegCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rfae_pkg::rf_req_t             req_i,
  output logic [rfae_pkg::DataW-1:0]    rdata0_o,
  output logic [rfae_pkg::DataW-1:0]    rdata1_o
);
  import rfae_pkg::*;

  localparam int unsigned Depth = (RegCount < IdxSpan) ? RegCount : IdxSpan;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [IdxW:0] Lim = (IdxW+1)'(Depth);

  logic [DataW-1:0] mem_q [Depth];
  logic [Depth-1:0] valid_q;
  logic [DataW-1:0] rd0_q, rd1_q;
  logic             ok0_q, ok1_q;
  logic             in0, in1, inw;

  assign in0 = {1'b0, req_i.raddr0} < Lim;
  assign in1 = {1'b0, req_i.raddr1} < Lim;
  assign inw = {1'b0, req_i.waddr} < Lim;

  always_ff @(posedge clk_i) begin
    if (req_i.we && inw) mem_q[req_i.waddr[AW-1:0]] <= req_i.wdata;
    rd0_q <= mem_q[req_i.raddr0[AW-1:0]];
    rd1_q <= mem_q[req_i.raddr1[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      ok0_q   <= 1'b0;
      ok1_q   <= 1'b0;
    end else begin
      if (req_i.we && inw) valid_q[req_i.waddr[AW-1:0]] <= 1'b1;
      ok0_q <= in0 && valid_q[req_i.raddr0[AW-1:0]];
      ok1_q <= in1 && valid_q[req_i.raddr1[AW-1:0]];
    end
  end

  assign rdata0_o = ok0_q ? rd0_q : '0;
  assign rdata1_o = ok1_q ? rd1_q : '0;

endmodule

FILE: rtl/rfae_div.sv
// Divider: unsigned restoring divide, one quotient bit per cycle.
module rfae_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quot_o,
  output logic [31:0] rem_o
);
  logic [31:0] quo_q, dvs_q;
  logic [32:0] rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] shifted, diff;

  assign shifted = {rem_q[31:0], quo_q[31]};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!diff[32]) begin
        rem_q <= diff;
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= shifted;
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q[31:0];

endmodule

FILE: rtl/rfae_back.sv
// Back end: sequencer, ALU, multiplier, write-back and output register.
module rfae_back #(
  parameter int unsigned RegCount = rfae_pkg::RegCountDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  rfae_pkg::q_item_t          q_data_i,
  output logic                       pop_o,
  output rfae_pkg::rf_req_t          rf_req_o,
  input  logic [rfae_pkg::DataW-1:0] rdata0_i,
  input  logic [rfae_pkg::DataW-1:0] rdata1_i,
  output logic                       div_start_o,
  output logic [31:0]                div_dividend_o,
  output logic [31:0]                div_divisor_o,
  input  logic                       div_done_i,
  input  logic [31:0]                div_quot_i,
  input  logic [31:0]                div_rem_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output rfae_pkg::out_item_t        out_data_o
);
  import rfae_pkg::*;

  localparam logic [IdxW:0] Lim = (IdxW+1)'((RegCount < IdxSpan) ? RegCount : IdxSpan);

  state_e      state_q, state_d;
  q_item_t     cur_q;
  logic [31:0] a_q, b_q, lo_q, hi_q;
  logic        wl_q, wh_q, negq_q, negr_q;
  logic [63:0] prod_q, acc_q;
  logic        out_valid_q;
  out_item_t   out_q;
  logic        d_ok, d2_ok, out_free;
  logic [31:0] alu_lo, c, imm, bmask, fmask;
  logic        alu_wl;
  logic [65:0] prod;
  logic [63:0] mac_sum;
  logic        na, nb;

  function automatic logic [31:0] clz(input logic [31:0] v);
    logic [31:0] n;
    n = 32'd32;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) n = 32'(31 - i);
    end
    return n;
  endfunction

  function automatic logic [31:0] sar(input logic [31:0] v, input logic [31:0] n);
    logic [4:0] s;
    s = (n > 32'd31) ? 5'd31 : n[4:0];
    return 32'($signed(v) >>> s);
  endfunction

  function automatic logic [31:0] shl(input logic [31:0] v, input logic [31:0] n);
    return (n > 32'd31) ? 32'd0 : (v << n[4:0]);
  endfunction

  function automatic logic [31:0] shr(input logic [31:0] v, input logic [31:0] n);
    return (n > 32'd31) ? 32'd0 : (v >> n[4:0]);
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] w;
    w = {v, v} >> n;
    return w[31:0];
  endfunction

  assign d_ok     = {1'b0, cur_q.item.dest_reg} < Lim;
  assign d2_ok    = {1'b0, cur_q.item.dest2_reg} < Lim;
  assign out_free = !out_valid_q || !out_stall_i;
  assign c        = rdata0_i;
  assign imm      = cur_q.item.imm;
  assign fmask    = (32'd1 << cur_q.item.field_count) - 32'd1;
  assign bmask    = fmask << cur_q.item.field_start;

  always_comb begin
    alu_wl = 1'b1;
    alu_lo = '0;
    unique case (cmd_e'(cur_q.item.cmd))
      CMD_MOVE:   alu_lo = a_q;
      CMD_SELECT: alu_lo = (c != '0) ? a_q : b_q;
      CMD_ADD:    alu_lo = a_q + b_q;
      CMD_SUB:    alu_lo = a_q - b_q;
      CMD_AND:    alu_lo = a_q & b_q;
      CMD_OR:     alu_lo = a_q | b_q;
      CMD_XOR:    alu_lo = a_q ^ b_q;
      CMD_NOT:    alu_lo = ~a_q;
      CMD_SLL:    alu_lo = shl(a_q, b_q);
      CMD_SRL:    alu_lo = shr(a_q, b_q);
      CMD_SRA:    alu_lo = sar(a_q, b_q);
      CMD_ROR:    alu_lo = rotr(a_q, b_q[4:0]);
      CMD_CLZ:    alu_lo = clz(a_q);
      CMD_CLO:    alu_lo = clz(~a_q);
      CMD_SLTU:   alu_lo = {31'd0, a_q < b_q};
      CMD_SLTS:   alu_lo = {31'd0, $signed(a_q) < $signed(b_q)};
      CMD_BSWAPH: alu_lo = {a_q[23:16], a_q[31:24], a_q[7:0], a_q[15:8]};
      CMD_BSWAPW: alu_lo = {a_q[7:0], a_q[15:8], a_q[23:16], a_q[31:24]};
      CMD_HSWAPW: alu_lo = {a_q[15:0], a_q[31:16]};
      CMD_ADDI:   alu_lo = a_q + imm;
      CMD_ANDI:   alu_lo = a_q & imm;
      CMD_ORI:    alu_lo = a_q | imm;
      CMD_XORI:   alu_lo = a_q ^ imm;
      CMD_SLLI:   alu_lo = shl(a_q, imm);
      CMD_SRLI:   alu_lo = shr(a_q, imm);
      CMD_SRAI:   alu_lo = sar(a_q, imm);
      CMD_RORI:   alu_lo = rotr(a_q, imm[4:0]);
      CMD_SLTUI:  alu_lo = {31'd0, a_q < imm};
      CMD_SLTSI:  alu_lo = {31'd0, $signed(a_q) < $signed(imm)};
      CMD_BFEXT:  alu_lo = (a_q >> cur_q.item.field_start) & fmask;
      CMD_BFINS:  alu_lo = (a_q & ~bmask) | ((b_q & fmask) << cur_q.item.field_start);
      CMD_LI:     alu_lo = imm;
      default:    alu_wl = 1'b0;
    endcase
  end

  assign prod = 66'($signed({cur_q.sgn & a_q[31], a_q}) * $signed({cur_q.sgn & b_q[31], b_q}));
  assign mac_sum = prod_q + acc_q;
  assign na = cur_q.sgn & a_q[31];
  assign nb = cur_q.sgn & b_q[31];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (q_valid_i) state_d = ST_RD_AB;
      ST_RD_AB: state_d = ST_RD_CX;
      ST_RD_CX: state_d = ST_EXEC;
      ST_EXEC: begin
        unique case (cur_q.cls)
          CLS_MUL, CLS_MAC: state_d = ST_MAC;
          CLS_DIV:          state_d = (b_q == '0) ? ST_OUT : ST_DIV;
          CLS_ALU:          state_d = ST_WR_LO;
          default:          state_d = ST_OUT;
        endcase
      end
      ST_MAC:   state_d = ST_WR_LO;
      ST_DIV:   if (div_done_i) state_d = ST_WR_LO;
      ST_WR_LO: state_d = ST_WR_HI;
      ST_WR_HI: state_d = ST_OUT;
      ST_OUT:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop_o           = 1'b0;
    div_start_o     = 1'b0;
    rf_req_o.raddr0 = cur_q.item.src1_reg;
    rf_req_o.raddr1 = cur_q.item.src2_reg;
    rf_req_o.we     = 1'b0;
    rf_req_o.waddr  = cur_q.item.dest_reg;
    rf_req_o.wdata  = lo_q;
    unique case (state_q)
      ST_IDLE: pop_o = q_valid_i;
      ST_RD_CX: begin
        rf_req_o.raddr0 = (cur_q.cls == CLS_MAC) ? cur_q.item.dest_reg : cur_q.item.sel_reg;
        rf_req_o.raddr1 = cur_q.item.dest2_reg;
      end
      ST_EXEC: div_start_o = (cur_q.cls == CLS_DIV) && (b_q != '0);
      ST_WR_LO: rf_req_o.we = wl_q;
      ST_WR_HI: begin
        rf_req_o.we    = wh_q;
        rf_req_o.waddr = cur_q.item.dest2_reg;
        rf_req_o.wdata = hi_q;
      end
      default: ;
    endcase
  end

  assign div_dividend_o = na ? (32'd0 - a_q) : a_q;
  assign div_divisor_o  = nb ? (32'd0 - b_q) : b_q;

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: cur_q <= q_data_i;
      ST_RD_CX: begin
        a_q <= rdata0_i;
        b_q <= rdata1_i;
      end
      ST_EXEC: begin
        prod_q <= prod[63:0];
        acc_q  <= (cur_q.cls == CLS_MAC) ? {rdata1_i, rdata0_i} : 64'd0;
        negq_q <= na ^ nb;
        negr_q <= na;
        lo_q   <= alu_lo;
        hi_q   <= '0;
        unique case (cur_q.cls)
          CLS_MUL, CLS_MAC: begin
            wl_q <= d_ok;
            wh_q <= d2_ok;
          end
          CLS_DIV: begin
            wl_q <= d_ok && (b_q != '0);
            wh_q <= d2_ok && (b_q != '0);
          end
          CLS_ALU: begin
            wl_q <= d_ok && alu_wl;
            wh_q <= 1'b0;
          end
          default: begin
            wl_q <= 1'b0;
            wh_q <= 1'b0;
          end
        endcase
      end
      ST_MAC: begin
        lo_q <= mac_sum[31:0];
        hi_q <= mac_sum[63:32];
      end
      ST_DIV: begin
        lo_q <= negq_q ? (32'd0 - div_quot_i) : div_quot_i;
        hi_q <= negr_q ? (32'd0 - div_rem_i) : div_rem_i;
      end
      default: ;
    endcase
    if (state_q == ST_OUT && out_free) begin
      out_q.low_result   <= wl_q ? lo_q : '0;
      out_q.high_result  <= wh_q ? hi_q : '0;
      out_q.low_written  <= wl_q;
      out_q.high_written <= wh_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: rtl/register_file_alu_executor_core.sv
// Top level: register file ALU executor with queued front end and sequenced back end.
// Each instruction goes from the queue head through dequeue, two operand reads, execute, two
// write-back slots and output (multiply and multiply-accumulate add a sum step, divide uses
// the restoring divider, which makes one quotient bit per cycle, and nop, unknown operations
// and divide by zero skip write-back slots); the back end runs one instruction at a time
// while the two-entry front queue accepts until full. The register file has two read ports
// and one write port, so operand reads and write-backs each come in two steps. Registers
// read as zero after reset, as do indexes at or above REG_COUNT, which are never written.
module register_file_alu_executor_core #(
  parameter int unsigned REG_COUNT = rfae_pkg::RegCountDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rfae_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rfae_pkg::out_item_t out_data_o
);
  import rfae_pkg::*;

  logic             q_valid, pop;
  q_item_t          q_data;
  rf_req_t          rf_req;
  logic [DataW-1:0] rdata0, rdata1;
  logic             div_start, div_done;
  logic [31:0]      div_dividend, div_divisor, div_quot, div_rem;

  rfae_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .pop_i(pop), .q_valid_o(q_valid), .q_data_o(q_data)
  );

  rfae_regs #(.RegCount(REG_COUNT)) u_regs (
    .clk_i, .rst_ni, .req_i(rf_req), .rdata0_o(rdata0), .rdata1_o(rdata1)
  );

  rfae_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_dividend),
    .divisor_i(div_divisor), .done_o(div_done), .quot_o(div_quot), .rem_o(div_rem)
  );

  rfae_back #(.RegCount(REG_COUNT)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_data_i(q_data), .pop_o(pop),
    .rf_req_o(rf_req), .rdata0_i(rdata0), .rdata1_i(rdata1),
    .div_start_o(div_start), .div_dividend_o(div_dividend), .div_divisor_o(div_divisor),
    .div_done_i(div_done), .div_quot_i(div_quot), .div_rem_i(div_rem),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

FILE: tb/register_file_alu_executor_core_tb.sv
// Testbench for the register file ALU executor: predicts each result and checks it in order.
`timescale 1ns / 100ps

module register_file_alu_executor_core_tb;
  import rfae_pkg::*;

  localparam int RegCount = 64;
  localparam int IdleLimit = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_data_o;

  logic [31:0] regs_model [RegCount];
  out_item_t result_queue[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit done_sending = 1'b0;

  register_file_alu_executor_core #(.REG_COUNT(RegCount)) u_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [31:0] reg_read(logic [5:0] idx);
    return (idx < RegCount) ? regs_model[idx] : 32'h0;
  endfunction

  function automatic logic [31:0] shift_arith(logic [31:0] v, logic [31:0] n);
    if (n > 31) n = 31;
    return $unsigned($signed(v) >>> n[4:0]);
  endfunction

  function automatic logic [31:0] rotate_right(logic [31:0] v, logic [31:0] n);
    logic [4:0] k;
    k = n[4:0];
    return (k == 0) ? v : ((v >> k) | (v << (6'd32 - k)));
  endfunction

  function automatic logic [31:0] lead_zeros(logic [31:0] v);
    int n;
    n = 0;
    while (n < 32 && !v[31]) begin
      v = v << 1;
      n++;
    end
    return n;
  endfunction

  function automatic out_item_t execute_instr(in_item_t it);
    logic [31:0] a, b, c, imm, lo, hi, ma, mb, q, r;
    logic [63:0] p, mask;
    logic wl, wh, na, nb;
    out_item_t res;
    a = reg_read(it.src1_reg);
    b = reg_read(it.src2_reg);
    c = reg_read(it.sel_reg);
    imm = it.imm;
    lo = '0; hi = '0; wl = 0; wh = 0;
    mask = (64'd1 << it.field_count) - 64'd1;
    case (it.cmd)
      CMD_MOVE:   begin lo = a; wl = 1; end
      CMD_SELECT: begin lo = (c != 0) ? a : b; wl = 1; end
      CMD_ADD:    begin lo = a + b; wl = 1; end
      CMD_SUB:    begin lo = a - b; wl = 1; end
      CMD_MULU, CMD_MADDU, CMD_MULS, CMD_MADDS: begin
        if (it.cmd == CMD_MULU || it.cmd == CMD_MADDU) p = {32'h0, a} * {32'h0, b};
        else p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
        if (it.cmd == CMD_MADDU || it.cmd == CMD_MADDS)
          p = p + {reg_read(it.dest2_reg), reg_read(it.dest_reg)};
        lo = p[31:0]; hi = p[63:32]; wl = 1; wh = 1;
      end
      CMD_DIVMODU: if (b != 0) begin lo = a / b; hi = a % b; wl = 1; wh = 1; end
      CMD_DIVMODS: if (b != 0) begin
        na = a[31]; nb = b[31];
        ma = na ? -a : a;
        mb = nb ? -b : b;
        q = ma / mb; r = ma % mb;
        lo = (na != nb) ? -q : q;
        hi = na ? -r : r;
        wl = 1; wh = 1;
      end
      CMD_AND:    begin lo = a & b; wl = 1; end
      CMD_OR:     begin lo = a | b; wl = 1; end
      CMD_XOR:    begin lo = a ^ b; wl = 1; end
      CMD_NOT:    begin lo = ~a; wl = 1; end
      CMD_SLL:    begin lo = (b < 32) ? a << b[4:0] : 0; wl = 1; end
      CMD_SRL:    begin lo = (b < 32) ? a >> b[4:0] : 0; wl = 1; end
      CMD_SRA:    begin lo = shift_arith(a, b); wl = 1; end
      CMD_ROR:    begin lo = rotate_right(a, b); wl = 1; end
      CMD_CLZ:    begin lo = lead_zeros(a); wl = 1; end
      CMD_CLO:    begin lo = lead_zeros(~a); wl = 1; end
      CMD_SLTU:   begin lo = {31'd0, a < b}; wl = 1; end
      CMD_SLTS:   begin lo = {31'd0, $signed(a) < $signed(b)}; wl = 1; end
      CMD_BSWAPH: begin lo = {a[23:16], a[31:24], a[7:0], a[15:8]}; wl = 1; end
      CMD_BSWAPW: begin lo = {a[7:0], a[15:8], a[23:16], a[31:24]}; wl = 1; end
      CMD_HSWAPW: begin lo = {a[15:0], a[31:16]}; wl = 1; end
      CMD_ADDI:   begin lo = a + imm; wl = 1; end
      CMD_ANDI:   begin lo = a & imm; wl = 1; end
      CMD_ORI:    begin lo = a | imm; wl = 1; end
      CMD_XORI:   begin lo = a ^ imm; wl = 1; end
      CMD_SLLI:   begin lo = (imm < 32) ? a << imm[4:0] : 0; wl = 1; end
      CMD_SRLI:   begin lo = (imm < 32) ? a >> imm[4:0] : 0; wl = 1; end
      CMD_SRAI:   begin lo = shift_arith(a, imm); wl = 1; end
      CMD_RORI:   begin lo = rotate_right(a, imm); wl = 1; end
      CMD_SLTUI:  begin lo = {31'd0, a < imm}; wl = 1; end
      CMD_SLTSI:  begin lo = {31'd0, $signed(a) < $signed(imm)}; wl = 1; end
      CMD_BFEXT:  begin p = {32'h0, a >> it.field_start} & mask; lo = p[31:0]; wl = 1; end
      CMD_BFINS: begin
        p = ({32'h0, a} & ~(mask << it.field_start)) | (({32'h0, b} & mask) << it.field_start);
        lo = p[31:0]; wl = 1;
      end
      CMD_LI:     begin lo = imm; wl = 1; end
      default: ;
    endcase
    if (wl) begin
      if (it.dest_reg < RegCount) regs_model[it.dest_reg] = lo;
      else wl = 0;
    end
    if (wh) begin
      if (it.dest2_reg < RegCount) regs_model[it.dest2_reg] = hi;
      else wh = 0;
    end
    res.low_result = wl ? lo : '0;
    res.high_result = wh ? hi : '0;
    res.low_written = wl;
    res.high_written = wh;
    return res;
  endfunction

  task automatic send_instr(in_item_t it);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    result_queue.push_back(execute_instr(it));
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 40);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t random_instr(bit full_range);
    in_item_t it;
    it.cmd = full_range ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 38));
    it.dest_reg = 6'($urandom);
    it.dest2_reg = 6'($urandom);
    it.src1_reg = 6'($urandom);
    it.src2_reg = 6'($urandom);
    it.sel_reg = 6'($urandom);
    it.imm = ($urandom_range(0, 2) == 0) ? 32'($urandom_range(0, 40)) : pick_value();
    it.field_start = 5'($urandom);
    it.field_count = 5'($urandom);
    return it;
  endfunction

  function automatic in_item_t make_instr(cmd_e op, logic [5:0] d, logic [5:0] d2,
                                          logic [5:0] s1, logic [5:0] s2, logic [31:0] imm);
    in_item_t it;
    it = '0;
    it.cmd = op; it.dest_reg = d; it.dest2_reg = d2;
    it.src1_reg = s1; it.src2_reg = s2; it.imm = imm;
    return it;
  endfunction

  task automatic test_directed();
    in_item_t it;
    send_instr(make_instr(CMD_LI, 1, 0, 0, 0, 32'h8000_0000));
    send_instr(make_instr(CMD_LI, 2, 0, 0, 0, 32'hFFFF_FFFF));
    send_instr(make_instr(CMD_LI, 3, 0, 0, 0, 32'd40));
    send_instr(make_instr(CMD_DIVMODS, 4, 5, 1, 2, 0));
    send_instr(make_instr(CMD_DIVMODU, 4, 5, 1, 0, 0));
    send_instr(make_instr(CMD_SRA, 6, 0, 1, 3, 0));
    send_instr(make_instr(CMD_SLL, 6, 0, 2, 3, 0));
    send_instr(make_instr(CMD_SRLI, 6, 0, 2, 0, 32'hFFFF_FFFF));
    send_instr(make_instr(CMD_RORI, 6, 0, 1, 0, 32'd33));
    send_instr(make_instr(CMD_CLZ, 7, 0, 0, 0, 0));
    send_instr(make_instr(CMD_CLO, 7, 0, 2, 0, 0));
    send_instr(make_instr(CMD_MADDS, 8, 9, 1, 2, 0));
    send_instr(make_instr(CMD_MADDU, 8, 9, 2, 2, 0));
    send_instr(make_instr(CMD_MULS, 10, 10, 1, 1, 0));
    send_instr(make_instr(CMD_MULU, 63, 62, 2, 2, 0));
    send_instr(make_instr(CMD_SLTSI, 11, 0, 1, 0, 32'h7FFF_FFFF));
    send_instr(make_instr(CMD_NOP, 12, 12, 1, 1, 0));
    send_instr(make_instr(cmd_e'(6'd63), 12, 12, 1, 1, 32'hFFFF_FFFF));
    it = make_instr(CMD_BFINS, 13, 0, 1, 2, 0);
    it.field_start = 5'd31; it.field_count = 5'd31;
    send_instr(it);
    it.field_count = 5'd0;
    send_instr(it);
    it.cmd = CMD_BFEXT; it.field_start = 5'd0; it.field_count = 5'd31;
    send_instr(it);
    send_instr(make_instr(CMD_SELECT, 14, 0, 1, 2, 0));
  endtask

  task automatic test_all_ops();
    for (int op = 0; op <= 38; op++) begin
      in_item_t it;
      it = random_instr(1'b0);
      it.cmd = op[5:0];
      send_instr(it);
    end
  endtask

  task automatic test_random();
    for (int n = 0; n < 1500; n++) send_instr(random_instr($urandom_range(0, 19) == 0));
  endtask

  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (out_valid_o && !out_stall_i) begin
      if (result_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %h", out_data_o);
      end else begin
        exp_res = result_queue.pop_front();
        if (out_data_o !== exp_res) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp_res, out_data_o);
        end
      end
    end
  end

  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (out_valid_o && !out_stall_i) begin
      if ($urandom_range(0, 2) == 0) begin
        stall_left <= $urandom_range(0, 10);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit && !done_sending) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int waited;
    for (int i = 0; i < RegCount; i++) regs_model[i] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_all_ops();
    test_random();
    in_valid_i <= 1'b0;
    waited = 0;
    while (result_queue.size() != 0 && waited < IdleLimit) begin
      @(posedge clk_i);
      waited++;
    end
    done_sending = 1'b1;
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && result_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
